### sv/fsl_pkg.sv
// Package for the fixed-slot free-list store: constants, codes, state type, byte mask.
// No dependencies; used by fsl_if, the top level and the testbench.
package fsl_pkg;

	localparam int SLOT_BYTES    = 8;
	localparam int CAPACITY      = 256;
	localparam int POINTER_BYTES = 4;

	localparam int SLOT_W = 64;
	localparam int LINK_W = 8 * POINTER_BYTES;

	typedef logic [1:0] cmd_t;
	localparam cmd_t CMD_ADD    = 2'd0;
	localparam cmd_t CMD_REMOVE = 2'd1;
	localparam cmd_t CMD_GET    = 2'd2;

	typedef logic [1:0] status_t;
	localparam status_t STATUS_OK        = 2'd0;
	localparam status_t STATUS_FULL      = 2'd1;
	localparam status_t STATUS_BAD_LEN   = 2'd2;
	localparam status_t STATUS_BAD_INDEX = 2'd3;

	typedef enum logic [1:0] {
		ST_IDLE,
		ST_READ,
		ST_EXEC,
		ST_RESP
	} state_t;

	// Low n bytes set, n up to 8.
	function automatic logic [SLOT_W-1:0] byte_mask(input logic [3:0] n);
		logic [SLOT_W-1:0] m;
		m = '0;
		for (int b = 0; b < SLOT_W / 8; b++) begin
			m[8*b +: 8] = (4'(b) < n) ? 8'hFF : 8'h00;
		end
		return m;
	endfunction

	localparam logic [SLOT_W-1:0] SLOT_MASK = byte_mask(4'(SLOT_BYTES));

endpackage

### sv/fsl_if.sv
// Request and response channel interfaces for the fixed-slot free-list store.
// Depends on fsl_pkg for payload types.
interface fsl_req_if;
	logic                      valid;
	logic                      ready;
	fsl_pkg::cmd_t             command;
	logic [63:0]               value;
	logic [3:0]                value_length;
	logic [7:0]                slot_index;

	modport source (output valid, command, value, value_length, slot_index, input ready);
	modport sink (input valid, command, value, value_length, slot_index, output ready);
endinterface

interface fsl_rsp_if;
	logic                      valid;
	logic                      ready;
	logic [7:0]                assigned_slot;
	logic [63:0]               data;
	fsl_pkg::status_t          status;

	modport source (output valid, assigned_slot, data, status, input ready);
	modport sink (input valid, assigned_slot, data, status, output ready);
endinterface

### sv/fsl_mem.sv
// Slot memory: one write port, one read port with registered read data.
// Depends on nothing but its parameters.
module fsl_mem #(
	parameter int DEPTH = 256,
	parameter int W     = 64
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [W-1:0]             wdata,
	input  logic                     re,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [W-1:0]             rdata
);
	logic [W-1:0] slots_mem [DEPTH];
	logic [W-1:0] rdata_q;

	always_ff @(posedge clk) begin
		if (we) begin
			slots_mem[waddr] <= wdata;
		end
	end

	always_ff @(posedge clk) begin
		if (re) begin
			rdata_q <= slots_mem[raddr];
		end
	end

	assign rdata = rdata_q;
endmodule

### sv/fsl_cmp.sv
// Shared compare unit: registers a < b and a == 0 for the sequencer.
// Depends on nothing but its parameter.
module fsl_cmp #(
	parameter int W = 32
) (
	input  logic         clk,
	input  logic         en,
	input  logic [W-1:0] a,
	input  logic [W-1:0] b,
	output logic         lt,
	output logic         a_zero
);
	logic lt_q;
	logic a_zero_q;

	always_ff @(posedge clk) begin
		if (en) begin
			lt_q     <= a < b;
			a_zero_q <= a == '0;
		end
	end

	assign lt     = lt_q;
	assign a_zero = a_zero_q;
endmodule

### sv/fixed_slot_free_list_store_top.sv
// Top level of the fixed-slot free-list store: sequencer, head and count registers.
// Depends on fsl_pkg, fsl_if, fsl_mem and fsl_cmp.
//
// Usage:
//   req channel carries one command per item: add (value, value_length), remove or
//   get (slot_index). rsp channel returns one item per request: assigned_slot,
//   data and status (ok, full, bad length, bad index).
//   Each request runs through three internal steps: a memory read of the head's
//   slot or the indexed slot together with a range compare in the shared compare
//   unit, an execute step that writes the memory and updates head and count, and
//   a response step. The sequencer takes no new request until it is back in
//   idle; the single read and write port of the slot memory and the shared
//   comparator keep it to one request at a time.
//   req.ready is high only while the sequencer is idle.
//   The response sits in an output register; the next request is accepted while
//   it waits. The next response then holds in the response step until it is taken.
//   Reset empties the store: the free list head is cleared and only slot 0 is
//   counted. No clearing pass is needed.
module fixed_slot_free_list_store_top #(
	parameter int CAPACITY = fsl_pkg::CAPACITY
) (
	input  logic      clk,
	input  logic      arst_n,
	fsl_req_if.sink   req,
	fsl_rsp_if.source rsp
);
	import fsl_pkg::*;

	localparam int IDX_W = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
	localparam int CNT_W = $clog2(CAPACITY + 1);
	localparam int CMP_W = (LINK_W > CNT_W) ? LINK_W : CNT_W;

	state_t state_q, state_d;

	cmd_t             cmd_q;
	logic [63:0]      value_q;
	logic [3:0]       len_q;
	logic [7:0]       idx_q;
	logic [LINK_W-1:0] head_q;
	logic [CNT_W-1:0] count_q;

	logic [7:0]       res_slot_q;
	logic [63:0]      res_data_q;
	status_t          res_status_q;

	logic             out_valid_q;
	logic [7:0]       out_slot_q;
	logic [63:0]      out_data_q;
	status_t          out_status_q;

	logic             accept;
	logic             load_out;

	logic             mem_we;
	logic [IDX_W-1:0] mem_waddr;
	logic [SLOT_W-1:0] mem_wdata;
	logic             mem_re;
	logic [IDX_W-1:0] mem_raddr;
	logic [SLOT_W-1:0] mem_rdata;

	logic             cmp_en;
	logic [CMP_W-1:0] cmp_a;
	logic [CMP_W-1:0] cmp_b;
	logic             cmp_lt;
	logic             cmp_zero;

	logic             len_ok;
	logic             in_range;
	logic             is_full;
	logic [IDX_W-1:0] target;

	logic             head_ld;
	logic [LINK_W-1:0] head_d;
	logic             count_inc;
	logic [7:0]       res_slot_d;
	logic [63:0]      res_data_d;
	status_t          res_status_d;

	fsl_mem #(
		.DEPTH (CAPACITY),
		.W     (SLOT_W)
	) u_mem (
		.clk   (clk),
		.we    (mem_we),
		.waddr (mem_waddr),
		.wdata (mem_wdata),
		.re    (mem_re),
		.raddr (mem_raddr),
		.rdata (mem_rdata)
	);

	fsl_cmp #(
		.W (CMP_W)
	) u_cmp (
		.clk    (clk),
		.en     (cmp_en),
		.a      (cmp_a),
		.b      (cmp_b),
		.lt     (cmp_lt),
		.a_zero (cmp_zero)
	);

	assign accept   = req.valid && req.ready;
	assign load_out = (state_q == ST_RESP) && (!out_valid_q || rsp.ready);

	// Next state
	always_comb begin
		state_d = state_q;
		unique case (state_q)
			ST_IDLE: begin
				if (accept) state_d = ST_READ;
			end
			ST_READ: state_d = ST_EXEC;
			ST_EXEC: state_d = ST_RESP;
			ST_RESP: begin
				if (load_out) state_d = ST_IDLE;
			end
			default: state_d = ST_IDLE;
		endcase
	end

	// Ready while idle; read step: address and compare operands follow the command
	always_comb begin
		req.ready = 1'b0;
		mem_re    = 1'b0;
		cmp_en    = 1'b0;
		unique case (state_q)
			ST_IDLE: req.ready = 1'b1;
			ST_READ: begin
				mem_re = 1'b1;
				cmp_en = 1'b1;
			end
			ST_EXEC: ;
			ST_RESP: ;
			default: ;
		endcase
	end

	assign mem_raddr = (cmd_q == CMD_ADD) ? IDX_W'(head_q) : IDX_W'(idx_q);
	assign cmp_a     = (cmd_q == CMD_ADD) ? CMP_W'(head_q) : CMP_W'(idx_q);
	assign cmp_b     = CMP_W'(count_q);

	// head (add) or slot_index (remove/get) is nonzero and below the count
	assign in_range = !cmp_zero && cmp_lt;
	assign len_ok   = (len_q > 4'(SLOT_BYTES / 2)) && (len_q <= 4'(SLOT_BYTES));
	assign is_full  = count_q == CNT_W'(CAPACITY);
	assign target   = in_range ? IDX_W'(head_q) : IDX_W'(count_q);

	// Execute step
	always_comb begin
		mem_we       = 1'b0;
		mem_waddr    = target;
		mem_wdata    = value_q & byte_mask(len_q) & SLOT_MASK;
		head_ld      = 1'b0;
		head_d       = mem_rdata[LINK_W-1:0];
		count_inc    = 1'b0;
		res_slot_d   = '0;
		res_data_d   = '0;
		res_status_d = STATUS_OK;
		if (state_q == ST_EXEC) begin
			case (cmd_q)
				CMD_ADD: begin
					if (!len_ok) begin
						res_status_d = STATUS_BAD_LEN;
					end else if (in_range) begin
						mem_we     = 1'b1;
						head_ld    = 1'b1;
						res_slot_d = 8'(target);
					end else if (is_full) begin
						res_status_d = STATUS_FULL;
					end else begin
						mem_we     = 1'b1;
						count_inc  = 1'b1;
						res_slot_d = 8'(target);
					end
				end
				CMD_REMOVE, CMD_GET: begin
					if (!in_range) begin
						res_status_d = STATUS_BAD_INDEX;
					end else begin
						res_data_d = mem_rdata & SLOT_MASK;
						if (cmd_q == CMD_REMOVE) begin
							mem_we    = 1'b1;
							mem_waddr = IDX_W'(idx_q);
							mem_wdata = SLOT_W'(head_q);
							head_ld   = 1'b1;
							head_d    = LINK_W'(idx_q);
						end
					end
				end
				default: res_status_d = STATUS_BAD_INDEX;
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			head_q      <= '0;
			count_q     <= CNT_W'(1);
			out_valid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			if (head_ld) head_q <= head_d;
			if (count_inc) count_q <= count_q + CNT_W'(1);
			if (load_out) begin
				out_valid_q <= 1'b1;
			end else if (rsp.ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			cmd_q   <= req.command;
			value_q <= req.value;
			len_q   <= req.value_length;
			idx_q   <= req.slot_index;
		end
		if (state_q == ST_EXEC) begin
			res_slot_q   <= res_slot_d;
			res_data_q   <= res_data_d;
			res_status_q <= res_status_d;
		end
		if (load_out) begin
			out_slot_q   <= res_slot_q;
			out_data_q   <= res_data_q;
			out_status_q <= res_status_q;
		end
	end

	assign rsp.valid         = out_valid_q;
	assign rsp.assigned_slot = out_slot_q;
	assign rsp.data          = out_data_q;
	assign rsp.status        = out_status_q;

	// Checks
	a_count_range: assert property (@(posedge clk) disable iff (!arst_n)
		(count_q >= CNT_W'(1)) && (count_q <= CNT_W'(CAPACITY)))
		else $error("slot count out of range");

	a_accept_starts_read: assert property (@(posedge clk) disable iff (!arst_n)
		accept |=> (state_q == ST_READ))
		else $error("accepted item did not start a read");

	a_write_in_exec: assert property (@(posedge clk) disable iff (!arst_n)
		mem_we |-> (state_q == ST_EXEC))
		else $error("slot memory written outside execute step");

	a_count_step: assert property (@(posedge clk) disable iff (!arst_n)
		(count_q != $past(count_q)) |-> (count_q == $past(count_q) + CNT_W'(1)))
		else $error("slot count moved by more than one");

endmodule

### bench/testbench.sv
// Self-checking bench for fixed_slot_free_list_store_top: directed error and free-list cases,
// a fill to capacity and random add/remove/get traffic under four idling mixes.
// Depends on fsl_pkg, fsl_if and the block's RTL.
module testbench;
	timeunit 1ns;
	timeprecision 1ps;

	import fsl_pkg::*;

	localparam cmd_t CMD_UNUSED  = 2'd3;
	localparam int   CYCLE_LIMIT = 500000;
	localparam int   SHOW_LIMIT  = 10;

	typedef struct packed {
		logic [7:0]  assigned_slot;
		logic [63:0] data;
		status_t     status;
	} store_reply_t;

	logic clk;
	logic arst_n;

	fsl_req_if req_ch ();
	fsl_rsp_if rsp_ch ();

	fixed_slot_free_list_store_top DUT (
		.clk    (clk),
		.arst_n (arst_n),
		.req    (req_ch),
		.rsp    (rsp_ch)
	);

	// shadow of the slot memory and allocation count
	logic [63:0]  slot_mem [CAPACITY];
	logic [8:0]   in_use;
	bit           live [CAPACITY];

	store_reply_t expected_replies [$];
	status_t      last_status;
	int           status_seen [4];
	int           sent_count;
	int           checked_count;
	int           mismatch_count;
	int           sender_idle_pct;
	int           receiver_stall_pct;

	initial begin
		clk = 1'b0;
		forever #2 clk = ~clk;
	end

	function automatic void store_clear();
		foreach (slot_mem[i]) begin
			slot_mem[i] = '0;
			live[i] = 1'b0;
		end
		in_use = 9'd1;
	endfunction

	function automatic store_reply_t store_predict(input cmd_t cmd, input logic [63:0] value,
			input logic [3:0] len, input logic [7:0] idx);
		store_reply_t r;
		logic [LINK_W-1:0] head;
		logic [63:0] keep;
		int target;
		r = '0;
		target = 0;
		case (cmd)
		CMD_ADD: begin
			if (len <= SLOT_BYTES / 2 || len > SLOT_BYTES) begin
				r.status = STATUS_BAD_LEN;
			end else begin
				head = slot_mem[0][LINK_W-1:0];
				// a head link past the allocated range counts as an empty list
				if (head != 0 && head < in_use && head < CAPACITY) begin
					target = int'(head);
					slot_mem[0] = 64'(slot_mem[target][LINK_W-1:0]);
				end else if (in_use >= CAPACITY) begin
					r.status = STATUS_FULL;
				end else begin
					target = int'(in_use);
					in_use++;
				end
				if (r.status == STATUS_OK) begin
					keep = (len >= 8) ? '1 : (64'd1 << (8 * len)) - 64'd1;
					slot_mem[target] = value & keep & SLOT_MASK;
					r.assigned_slot = 8'(target);
				end
			end
		end
		CMD_REMOVE, CMD_GET: begin
			if (idx == 0 || idx >= in_use) begin
				r.status = STATUS_BAD_INDEX;
			end else begin
				r.data = slot_mem[idx] & SLOT_MASK;
				if (cmd == CMD_REMOVE) begin
					// freed slot links to the old head; no check for a slot already free
					slot_mem[idx] = 64'(slot_mem[0][LINK_W-1:0]);
					slot_mem[0] = 64'(idx);
				end
			end
		end
		default: begin
			r.status = STATUS_BAD_INDEX;
		end
		endcase
		return r;
	endfunction

	// Called on a falling edge; returns on the falling edge after the item is taken.
	task automatic send_req(input cmd_t cmd, input logic [63:0] value, input logic [3:0] len,
			input logic [7:0] idx);
		store_reply_t r;
		while ($urandom_range(99) < sender_idle_pct) begin
			req_ch.valid        <= 1'b0;
			req_ch.command      <= cmd_t'($urandom_range(3));
			req_ch.value        <= {$urandom, $urandom};
			req_ch.value_length <= 4'($urandom_range(15));
			req_ch.slot_index   <= 8'($urandom_range(255));
			@(negedge clk);
		end
		req_ch.valid        <= 1'b1;
		req_ch.command      <= cmd;
		req_ch.value        <= value;
		req_ch.value_length <= len;
		req_ch.slot_index   <= idx;
		do @(posedge clk); while (!req_ch.ready);
		r = store_predict(cmd, value, len, idx);
		expected_replies.push_back(r);
		if (r.status == STATUS_OK && cmd == CMD_ADD)
			live[r.assigned_slot] = 1'b1;
		if (r.status == STATUS_OK && cmd == CMD_REMOVE)
			live[idx] = 1'b0;
		last_status = r.status;
		status_seen[r.status]++;
		sent_count++;
		@(negedge clk);
	endtask

	task automatic send_noise();
		send_req(cmd_t'($urandom_range(3)), {$urandom, $urandom}, 4'($urandom_range(15)),
			8'($urandom_range(255)));
	endtask

	task automatic test_error_statuses();
		send_req(CMD_GET, '0, 4'd8, 8'd0);
		send_req(CMD_GET, '0, 4'd8, 8'd1);      // nothing allocated yet
		send_req(CMD_REMOVE, '0, 4'd8, 8'd255);
		send_req(CMD_UNUSED, '1, 4'd8, 8'd1);
		send_req(CMD_ADD, '1, 4'd0, 8'd0);
		send_req(CMD_ADD, '1, 4'd4, 8'd0);      // exactly half a slot
		send_req(CMD_ADD, '1, 4'd9, 8'd0);
		send_req(CMD_ADD, '1, 4'd15, 8'd255);
	endtask

	task automatic test_free_list_links();
		send_req(CMD_ADD, '1, 4'd5, 8'd0);
		send_req(CMD_ADD, '1, 4'd8, 8'd0);
		send_req(CMD_ADD, {$urandom, $urandom}, 4'd6, 8'd0);
		send_req(CMD_ADD, '0, 4'd7, 8'd0);
		send_req(CMD_GET, '0, 4'd0, 8'd1);
		send_req(CMD_GET, '0, 4'd0, 8'd2);
		send_req(CMD_GET, '0, 4'd0, 8'd4);
		send_req(CMD_GET, '0, 4'd0, 8'd5);      // at the count, one past the last slot
		send_req(CMD_REMOVE, '0, 4'd0, 8'd2);
		send_req(CMD_REMOVE, '0, 4'd0, 8'd3);
		send_req(CMD_GET, '0, 4'd0, 8'd3);      // reads back the link to slot 2
		send_req(CMD_REMOVE, '0, 4'd0, 8'd3);   // slot 3 freed twice, links to itself
		send_req(CMD_ADD, '1, 4'd8, 8'd0);
		send_req(CMD_ADD, {$urandom, $urandom}, 4'd8, 8'd0);  // head now takes an all-ones link
		send_req(CMD_ADD, {$urandom, $urandom}, 4'd5, 8'd0);
		send_req(CMD_GET, '0, 4'd0, 8'd5);
	endtask

	task automatic test_fill_to_capacity();
		int full_replies;
		int guard;
		int pick;
		full_replies = 0;
		guard = 0;
		while (full_replies < 6 && guard < 800) begin
			pick = $urandom_range(99);
			if (pick < 85)
				send_req(CMD_ADD, {$urandom, $urandom}, 4'($urandom_range(8, 5)), 8'd0);
			else if (pick < 95)
				send_req(CMD_GET, '0, 4'd0, 8'($urandom_range(int'(in_use) - 1, 1)));
			else
				send_noise();
			if (last_status == STATUS_FULL)
				full_replies++;
			guard++;
		end
	endtask

	task automatic test_free_list_churn(input int items, input int idle_pct, input int stall_pct);
		int pick;
		int idx;
		sender_idle_pct = idle_pct;
		receiver_stall_pct = stall_pct;
		repeat (items) begin
			pick = $urandom_range(99);
			if (pick < 35) begin
				if ($urandom_range(9) == 0)
					send_req(CMD_ADD, {$urandom, $urandom}, 4'($urandom_range(15)), 8'd0);
				else
					send_req(CMD_ADD, {$urandom, $urandom}, 4'($urandom_range(8, 5)), 8'd0);
			end else if (pick < 60) begin
				// prefer a slot in use; a miss falls through to a double free
				idx = $urandom_range(int'(in_use) - 1, 1);
				for (int t = 0; t < 8 && !live[idx]; t++)
					idx = $urandom_range(int'(in_use) - 1, 1);
				send_req(CMD_REMOVE, {$urandom, $urandom}, 4'($urandom_range(15)), 8'(idx));
			end else if (pick < 85) begin
				send_req(CMD_GET, {$urandom, $urandom}, 4'($urandom_range(15)),
					8'($urandom_range(int'(in_use) - 1, 1)));
			end else begin
				send_noise();
			end
		end
	endtask

	initial begin : reply_sink
		rsp_ch.ready = 1'b0;
		forever begin
			@(negedge clk);
			rsp_ch.ready <= ($urandom_range(99) >= receiver_stall_pct);
		end
	end

	initial begin : reply_checker
		store_reply_t want;
		forever begin
			@(posedge clk);
			if (arst_n && rsp_ch.valid && rsp_ch.ready) begin
				if (expected_replies.size() == 0) begin
					mismatch_count++;
					if (mismatch_count <= SHOW_LIMIT)
						$display("unexpected reply: slot %0d data %h status %0d",
							rsp_ch.assigned_slot, rsp_ch.data, rsp_ch.status);
				end else begin
					want = expected_replies.pop_front();
					checked_count++;
					if (rsp_ch.assigned_slot !== want.assigned_slot || rsp_ch.data !== want.data
							|| rsp_ch.status !== want.status) begin
						mismatch_count++;
						if (mismatch_count <= SHOW_LIMIT)
							$display("reply %0d: expected slot %0d data %h status %0d, got slot %0d data %h status %0d",
								checked_count, want.assigned_slot, want.data, want.status,
								rsp_ch.assigned_slot, rsp_ch.data, rsp_ch.status);
					end
				end
			end
		end
	end

	initial begin : watchdog
		repeat (CYCLE_LIMIT) @(posedge clk);
		$display("timeout after %0d cycles, %0d replies outstanding", CYCLE_LIMIT,
			expected_replies.size());
		$display("SCOREBOARD MISMATCH");
		$finish;
	end

	initial begin
		arst_n              = 1'b0;
		req_ch.valid        = 1'b0;
		req_ch.command      = CMD_ADD;
		req_ch.value        = '0;
		req_ch.value_length = '0;
		req_ch.slot_index   = '0;
		sender_idle_pct     = 0;
		receiver_stall_pct  = 0;
		store_clear();
		repeat (7) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;
		@(negedge clk);

		test_error_statuses();
		test_free_list_links();
		test_fill_to_capacity();
		test_free_list_churn(320, 0, 0);
		test_free_list_churn(320, 48, 0);
		test_free_list_churn(320, 0, 48);
		test_free_list_churn(320, 17, 17);

		req_ch.valid <= 1'b0;
		receiver_stall_pct = 0;
		while (expected_replies.size() != 0) @(posedge clk);
		repeat (16) @(posedge clk);
		mismatch_count += expected_replies.size();

		$display("%0d requests, %0d replies checked, %0d mismatches", sent_count,
			checked_count, mismatch_count);
		$display("status mix: %0d ok, %0d full, %0d bad length, %0d bad index",
			status_seen[STATUS_OK], status_seen[STATUS_FULL], status_seen[STATUS_BAD_LEN],
			status_seen[STATUS_BAD_INDEX]);
		if (mismatch_count == 0)
			$display("SCOREBOARD CLEAN");
		else
			$display("SCOREBOARD MISMATCH");
		$finish;
	end

endmodule

### fixed_slot_free_list_store_top.f
sv/fsl_pkg.sv
sv/fsl_if.sv
sv/fsl_mem.sv
sv/fsl_cmp.sv
sv/fixed_slot_free_list_store_top.sv
bench/testbench.sv
